### sv/keyed_score_accumulator_table_assert.svh
// Assertion macros for the keyed score accumulator table
`ifndef KEYED_SCORE_ACCUMULATOR_TABLE_ASSERT_SVH
`define KEYED_SCORE_ACCUMULATOR_TABLE_ASSERT_SVH
`define KSAT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define KSAT_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`endif

### sv/ksat_pkg.sv
// Package for the keyed score accumulator table: types and constants
`timescale 1ns / 1ps
package ksat_pkg;
  localparam int SUM_W = 48;
  localparam int WGT_W = 40;
  localparam int CTX_W = 16;
  localparam int VAL_W = 16;
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_ACC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECAY = 2'd2;
  localparam logic [WGT_W-1:0] ONE_FIX = 40'd65536;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [WGT_W-1:0] WGT_MAX = {WGT_W{1'b1}};
  localparam logic [0:0] REG_DECAY = 1'b0;
  localparam logic [0:0] REG_DEFAULT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input word
    logic scan_rst;   // restart scan index
    logic scan_inc;   // advance scan index
    logic rd;         // issue read at scan index
    logic cmp;        // compare read entry, latch match
    logic wr_upd;     // write back updated entry at match index
    logic wr_new;     // write new entry at count
    logic dec_mul;    // multiply read entry
    logic dec_wr;     // write decayed entry
    logic res_hit;    // form result from matched entry
    logic res_miss;   // form miss / new / full result
    logic res_zero;   // all-zero result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;  // scan index reached fill count
    logic matched;
    logic full;
    logic [CMD_W-1:0] cmd;
  } sts_t;
endpackage

### sv/ksat_ram.sv
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module ksat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### sv/ksat_datapath.sv
// Datapath: entry memory, scan index, match, accumulate, decay and result
`timescale 1ns / 1ps
module ksat_datapath #(
  parameter int ENTRIES = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ksat_pkg::ctl_t            ctl,
  output ksat_pkg::sts_t            sts,
  input  logic [ksat_pkg::CMD_W-1:0] in_cmd,
  input  logic [31:0]               in_key,
  input  logic [ksat_pkg::CTX_W-1:0] in_ctx,
  input  logic [ksat_pkg::VAL_W-1:0] in_score,
  input  logic [ksat_pkg::VAL_W-1:0] decay_gain,
  input  logic [ksat_pkg::VAL_W-1:0] default_sum,
  output logic [ksat_pkg::SUM_W-1:0] res_sum,
  output logic [ksat_pkg::WGT_W-1:0] res_weight,
  output logic                      res_hit,
  output logic                      res_status
);
  import ksat_pkg::*;
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = AW + 1;
  localparam int KB = (KEY_BITS >= 32) ? 32 : KEY_BITS;
  localparam int KW = CTX_W + KB;
  localparam int EW = KW + SUM_W + WGT_W;

  logic [CMD_W-1:0] cmd;
  logic [KW-1:0] key;
  logic [VAL_W-1:0] score;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [AW-1:0] match_idx;
  logic matched;
  logic [EW-1:0] rdata, wdata;
  logic we;
  logic [AW-1:0] addr;
  logic [KW-1:0] r_key;
  logic [KW-1:0] m_key;
  logic [SUM_W-1:0] r_sum, m_sum;
  logic [WGT_W-1:0] r_wgt, m_wgt;
  logic [SUM_W+VAL_W:0] acc_sum;
  logic [WGT_W:0] acc_wgt;
  logic [SUM_W+VAL_W-1:0] prod_sum;
  logic [WGT_W+VAL_W-1:0] prod_wgt;
  logic [SUM_W-1:0] upd_sum;
  logic [WGT_W-1:0] upd_wgt;
  logic [AW-1:0] wr_idx;

  assign {r_key, r_sum, r_wgt} = rdata;
  assign acc_sum = {{(VAL_W+1){1'b0}}, m_sum} + {{(SUM_W-VAL_W+1){1'b0}}, score, {VAL_W{1'b0}}};
  assign acc_wgt = {1'b0, m_wgt} + {1'b0, ONE_FIX};

  always_comb begin
    upd_sum = (acc_sum > {{(VAL_W+1){1'b0}}, SUM_MAX}) ? SUM_MAX : acc_sum[SUM_W-1:0];
    upd_wgt = acc_wgt[WGT_W] ? WGT_MAX : acc_wgt[WGT_W-1:0];
    we = ctl.wr_upd | ctl.wr_new | ctl.dec_wr;
    addr = idx[AW-1:0];
    wdata = {key, {(SUM_W-2*VAL_W){1'b0}}, score, {VAL_W{1'b0}}, ONE_FIX};
    if (ctl.wr_upd) begin
      addr = match_idx;
      wdata = {key, upd_sum, upd_wgt};
    end else if (ctl.wr_new) begin
      addr = count[AW-1:0];
    end else if (ctl.dec_wr) begin
      addr = wr_idx;
      wdata = {key, prod_sum[SUM_W+VAL_W-1:VAL_W], prod_wgt[WGT_W+VAL_W-1:VAL_W]};
      wdata[EW-1:EW-KW] = m_key;
    end
  end

  ksat_ram #(.WIDTH(EW), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= in_cmd;
      key <= {in_ctx, in_key[KB-1:0]};
      score <= in_score;
    end
    if (ctl.cmp && r_key == key && !matched) begin
      match_idx <= wr_idx;
      m_sum <= r_sum;
      m_wgt <= r_wgt;
    end
    if (ctl.rd) begin
      wr_idx <= idx[AW-1:0];
    end
    if (ctl.dec_mul) begin
      m_key <= r_key;
      prod_sum <= r_sum * {{(SUM_W-VAL_W){1'b0}}, decay_gain}
                  + {{(SUM_W+VAL_W-16){1'b0}}, 16'd32768};
      prod_wgt <= r_wgt * {{(WGT_W-VAL_W){1'b0}}, decay_gain}
                  + {{(WGT_W+VAL_W-16){1'b0}}, 16'd32768};
    end
    if (ctl.res_hit) begin
      res_sum <= (cmd == CMD_ACC) ? upd_sum : m_sum;
      res_weight <= (cmd == CMD_ACC) ? upd_wgt : m_wgt;
      res_hit <= 1'b1;
      res_status <= 1'b0;
    end else if (ctl.res_miss) begin
      res_hit <= 1'b0;
      if (cmd == CMD_LOOKUP) begin
        res_sum <= {{(SUM_W-2*VAL_W){1'b0}}, default_sum, {VAL_W{1'b0}}};
        res_weight <= ONE_FIX;
        res_status <= 1'b0;
      end else if (count == CW'(ENTRIES)) begin
        res_sum <= '0;
        res_weight <= '0;
        res_status <= 1'b1;
      end else begin
        res_sum <= {{(SUM_W-2*VAL_W){1'b0}}, score, {VAL_W{1'b0}}};
        res_weight <= ONE_FIX;
        res_status <= 1'b0;
      end
    end else if (ctl.res_zero) begin
      res_sum <= '0;
      res_weight <= '0;
      res_hit <= 1'b0;
      res_status <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx <= '0;
      matched <= 1'b0;
    end else begin
      if (ctl.scan_rst) begin
        idx <= '0;
        matched <= 1'b0;
      end else if (ctl.scan_inc) begin
        idx <= idx + 1'b1;
      end
      if (ctl.cmp && r_key == key) begin
        matched <= 1'b1;
      end
      if (ctl.wr_new) begin
        count <= count + 1'b1;
      end
    end
  end

  assign sts.scan_done = (idx == count);
  assign sts.matched = matched;
  assign sts.full = (count == CW'(ENTRIES));
  assign sts.cmd = cmd;
endmodule

### sv/ksat_ctrl.sv
// Controller: command sequencing over the entry scan
`timescale 1ns / 1ps
`include "keyed_score_accumulator_table_assert.svh"
module ksat_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output ksat_pkg::ctl_t ctl,
  input  ksat_pkg::sts_t sts
);
  import ksat_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_SRD  = 4'd2;
  localparam logic [3:0] S_SCMP = 4'd3;
  localparam logic [3:0] S_FIN  = 4'd4;
  localparam logic [3:0] S_DRD  = 4'd5;
  localparam logic [3:0] S_DMUL = 4'd6;
  localparam logic [3:0] S_DMW  = 4'd7;
  localparam logic [3:0] S_DWR  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0] state, state_next;
  logic pending, pending_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    ctl = '0;
    state_next = state;
    pending_next = pending;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.load = 1'b1;
          ctl.scan_rst = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.cmd == CMD_ACC || sts.cmd == CMD_LOOKUP) begin
          state_next = S_SRD;
        end else if (sts.cmd == CMD_DECAY) begin
          state_next = S_DRD;
        end else begin
          ctl.res_zero = 1'b1;
          state_next = S_OUT;
        end
      end
      S_SRD: begin
        if (sts.scan_done || sts.matched) begin
          state_next = S_FIN;
        end else begin
          ctl.rd = 1'b1;
          ctl.scan_inc = 1'b1;
          state_next = S_SCMP;
        end
      end
      S_SCMP: begin
        ctl.cmp = 1'b1;
        state_next = S_SRD;
      end
      S_FIN: begin
        if (sts.matched) begin
          ctl.res_hit = 1'b1;
          ctl.wr_upd = (sts.cmd == CMD_ACC);
        end else begin
          ctl.res_miss = 1'b1;
          ctl.wr_new = (sts.cmd == CMD_ACC) && !sts.full;
        end
        state_next = S_OUT;
      end
      S_DRD: begin
        if (sts.scan_done) begin
          ctl.res_zero = 1'b1;
          state_next = S_OUT;
        end else begin
          ctl.rd = 1'b1;
          ctl.scan_inc = 1'b1;
          state_next = S_DMUL;
        end
      end
      S_DMUL: begin
        ctl.dec_mul = 1'b1;
        state_next = S_DWR;
      end
      S_DWR: begin
        ctl.dec_wr = 1'b1;
        state_next = S_DRD;
      end
      S_OUT: begin
        pending_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (out_valid && out_ready) begin
      pending_next = (state == S_OUT);
    end
  end

  assign out_valid = pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pending <= 1'b0;
    end else begin
      state <= state_next;
      pending <= pending_next;
    end
  end

  `KSAT_ASSERT(a_load_idle, !ctl.load || state == S_IDLE, "load outside idle")
  `KSAT_ASSERT_IMPL(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `KSAT_ASSERT(a_one_write, $countones({ctl.wr_upd, ctl.wr_new, ctl.dec_wr}) <= 1,
               "write conflict")
endmodule

### sv/keyed_score_accumulator_table.sv
// Top level of the keyed score accumulator table
//
// Input words on s_axis: command accumulate, lookup or decay with key, context and score.
// Each word gives one result word on m_axis: sum, weight, hit and table-full status.
// Configuration words on cfg: index 0 decay factor, index 1 default sum.
// An accumulate or lookup scans the filled slots in order through the single-port
// entry memory and stops at the first matching slot.
// A decay walks every filled slot, reading, scaling and writing back each one.
// One word is in flight; the next is taken once the result register is free or
// being taken in that same cycle.
// Reset empties the table at once by clearing the fill count; no clearing pass.
// A stalled receiver holds the result word and stops intake.
`timescale 1ns / 1ps
module keyed_score_accumulator_table #(
  parameter int ENTRIES = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // command, move_key, move_context, add_score, pad
  input  logic         m_axis_tready,
  output logic         m_axis_tvalid,
  output logic [87:0]  m_axis_tdata,   // score_sum, score_weight
  output logic [1:0]   m_axis_tuser,   // hit, status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import ksat_pkg::*;
  ctl_t ctl;
  sts_t sts;
  logic [VAL_W-1:0] decay_gain, default_sum;
  logic [SUM_W-1:0] r_sum;
  logic [WGT_W-1:0] r_wgt;
  logic r_hit, r_status;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_gain <= 16'd62259;
      default_sum <= 16'd100;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DECAY: decay_gain <= cfg_data;
        REG_DEFAULT: default_sum <= cfg_data;
        default: ;
      endcase
    end
  end

  ksat_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .ctl(ctl), .sts(sts)
  );

  ksat_datapath #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .sts(sts),
    .in_cmd(s_axis_tdata[1:0]), .in_key(s_axis_tdata[33:2]),
    .in_ctx(s_axis_tdata[49:34]), .in_score(s_axis_tdata[65:50]),
    .decay_gain(decay_gain), .default_sum(default_sum),
    .res_sum(r_sum), .res_weight(r_wgt), .res_hit(r_hit), .res_status(r_status)
  );

  assign m_axis_tdata = {r_wgt, r_sum};
  assign m_axis_tuser = {r_status, r_hit};
endmodule

### tb/tb_top.sv
// Self-checking testbench for the keyed score accumulator table
`timescale 1ns / 1ps
module tb_top;
  import ksat_pkg::*;

  localparam int ENTRIES = 1024;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int POOL = 48;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [WGT_W-1:0] weight;
    logic             hit;
    logic             status;
  } score_res_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // command, move_key, move_context, add_score, pad
  logic         m_axis_tready = 1'b0;
  logic         m_axis_tvalid;
  logic [87:0]  m_axis_tdata;        // score_sum, score_weight
  logic [1:0]   m_axis_tuser;        // hit, status
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [0:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  keyed_score_accumulator_table i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // table copy
  logic [47:0]      tbl_key [ENTRIES];
  logic [SUM_W-1:0] tbl_sum [ENTRIES];
  logic [WGT_W-1:0] tbl_wgt [ENTRIES];
  int               tbl_count;
  logic [15:0]      decay_mult;
  logic [15:0]      miss_sum;

  score_res_t pending_scores[$];
  int  errors = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  logic [31:0] pool_key [POOL];
  logic [15:0] pool_ctx [POOL];

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("keyed_score_accumulator_table: mismatch");
      $finish;
    end
  end

  function automatic int find_slot(logic [47:0] k);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_key[i] == k) return i;
    return -1;
  endfunction

  function automatic logic [63:0] decay_value(logic [63:0] v);
    logic [80:0] p;
    p = v * decay_mult + 81'd32768;
    return p[79:16];
  endfunction

  function automatic score_res_t predict_score(logic [1:0] cmd, logic [31:0] mk,
                                               logic [15:0] ctx, logic [15:0] sc);
    score_res_t r;
    logic [47:0] k;
    logic [48:0] s;
    logic [40:0] w;
    int idx;
    r = '0;
    k = {ctx, mk};
    idx = find_slot(k);
    case (cmd)
      CMD_ACC: begin
        if (idx >= 0) begin
          s = tbl_sum[idx] + ({32'd0, sc} << 16);
          w = tbl_wgt[idx] + ONE_FIX;
          tbl_sum[idx] = s[48] ? SUM_MAX : s[47:0];
          tbl_wgt[idx] = w[40] ? WGT_MAX : w[39:0];
          r.sum = tbl_sum[idx];
          r.weight = tbl_wgt[idx];
          r.hit = 1'b1;
        end else if (tbl_count < ENTRIES) begin
          tbl_key[tbl_count] = k;
          tbl_sum[tbl_count] = {32'd0, sc} << 16;
          tbl_wgt[tbl_count] = ONE_FIX;
          r.sum = tbl_sum[tbl_count];
          r.weight = ONE_FIX;
          tbl_count++;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_LOOKUP: begin
        if (idx >= 0) begin
          r.sum = tbl_sum[idx];
          r.weight = tbl_wgt[idx];
          r.hit = 1'b1;
        end else begin
          r.sum = {32'd0, miss_sum} << 16;
          r.weight = ONE_FIX;
        end
      end
      CMD_DECAY: begin
        for (int i = 0; i < tbl_count; i++) begin
          tbl_sum[i] = SUM_W'(decay_value(64'(tbl_sum[i])));
          tbl_wgt[i] = WGT_W'(decay_value(64'(tbl_wgt[i])));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("error %0s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 17);
  endfunction

  task automatic send_word(logic [1:0] cmd, logic [31:0] mk, logic [15:0] ctx,
                           logic [15:0] sc);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      @(negedge clk) s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tdata = {6'd0, sc, ctx, mk, cmd};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    pending_scores.push_back(predict_score(cmd, mk, ctx, sc));
  endtask

  task automatic drain();
    @(negedge clk) s_axis_tvalid = 1'b0;
    while (pending_scores.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    drain();
    @(negedge clk);
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DECAY) decay_mult = val;
    else miss_sum = val;
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  // result side
  initial begin
    score_res_t want;
    int stall;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      if (pending_scores.size() == 0) begin
        report("unexpected word", {40'd0, m_axis_tdata[47:0]}, 64'd0);
      end else begin
        want = pending_scores.pop_front();
        if (m_axis_tdata[47:0] != want.sum) report("sum", m_axis_tdata[47:0], want.sum);
        if (m_axis_tdata[87:48] != want.weight)
          report("weight", m_axis_tdata[87:48], want.weight);
        if (m_axis_tuser[0] != want.hit) report("hit", m_axis_tuser[0], want.hit);
        if (m_axis_tuser[1] != want.status) report("status", m_axis_tuser[1], want.status);
      end
      @(negedge clk);
    end
  end

  task automatic test_directed();
    send_word(CMD_LOOKUP, 32'd0, 16'h8000, 16'd0);
    send_word(CMD_ACC, 32'd0, 16'h8000, 16'hFFFF);
    send_word(CMD_ACC, 32'd0, 16'h8000, 16'hFFFF);
    send_word(CMD_LOOKUP, 32'd0, 16'h8000, 16'h1234);
    send_word(CMD_ACC, 32'hFFFF_FFFF, 16'h7FFF, 16'd0);
    send_word(CMD_ACC, 32'hFFFF_FFFF, 16'h7FFF, 16'd1);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
    send_word(CMD_ACC, 32'hA5A5_5A5A, 16'd0, 16'd300);
    send_word(CMD_UNUSED, 32'hA5A5_5A5A, 16'd0, 16'hFFFF);
    send_word(CMD_DECAY, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_word(CMD_LOOKUP, 32'd0, 16'h8000, 16'd0);
    send_word(CMD_LOOKUP, 32'hA5A5_5A5A, 16'd0, 16'd0);
    write_reg(REG_DEFAULT, 16'hFFFF);
    write_reg(REG_DECAY, 16'hFFFF);
    send_word(CMD_LOOKUP, 32'h1, 16'h1, 16'd0);
    send_word(CMD_DECAY, 32'd0, 16'd0, 16'd0);
    send_word(CMD_LOOKUP, 32'hFFFF_FFFF, 16'h7FFF, 16'd0);
    write_reg(REG_DEFAULT, 16'd0);
    write_reg(REG_DECAY, 16'd0);
    send_word(CMD_LOOKUP, 32'h2, 16'h2, 16'd0);
    send_word(CMD_DECAY, 32'd0, 16'd0, 16'd0);
    send_word(CMD_LOOKUP, 32'd0, 16'h8000, 16'd0);
    send_word(CMD_ACC, 32'd0, 16'h8000, 16'd7);
  endtask

  task automatic random_word();
    int p, c, sel;
    logic [31:0] mk;
    logic [15:0] ctx, sc;
    p = $urandom_range(0, POOL - 1);
    sel = $urandom_range(0, 9);
    mk = (sel == 0) ? $urandom() : pool_key[p];
    ctx = (sel == 0) ? 16'($urandom()) : pool_ctx[p];
    sc = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom());
    c = $urandom_range(0, 99);
    if (c < 50) send_word(CMD_ACC, mk, ctx, sc);
    else if (c < 85) send_word(CMD_LOOKUP, mk, ctx, sc);
    else if (c < 93) send_word(CMD_DECAY, mk, ctx, sc);
    else send_word(CMD_UNUSED, mk, ctx, sc);
  endtask

  task automatic test_random();
    for (int i = 0; i < POOL; i++) begin
      pool_key[i] = $urandom();
      pool_ctx[i] = 16'($urandom());
    end
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_DECAY, (ph == 0) ? 16'hFFFF : 16'($urandom()));
      write_reg(REG_DEFAULT, (ph == 1) ? 16'hFFFF : 16'($urandom()));
      quiet = (ph == 3);
      for (int n = 0; n < 60; n++) random_word();
    end
    quiet = 1'b0;
  endtask

  task automatic test_table_full();
    logic [31:0] mk;
    quiet = 1'b1;
    mk = 32'h4000_0000;
    while (tbl_count < ENTRIES) begin
      if (find_slot({16'h5A5A, mk}) < 0) send_word(CMD_ACC, mk, 16'h5A5A, 16'(mk));
      mk++;
    end
    quiet = 1'b0;
    send_word(CMD_ACC, 32'hDEAD_BEEF, 16'h0F0F, 16'd99);
    send_word(CMD_LOOKUP, 32'hDEAD_BEEF, 16'h0F0F, 16'd0);
    send_word(CMD_ACC, mk - 1, 16'h5A5A, 16'd5);
    send_word(CMD_ACC, 32'h1234_5678, 16'h8001, 16'hFFFF);
    write_reg(REG_DECAY, 16'd32768);
    send_word(CMD_DECAY, 32'd0, 16'd0, 16'd0);
    send_word(CMD_LOOKUP, mk - 1, 16'h5A5A, 16'd0);
  endtask

  initial begin
    tbl_count = 0;
    decay_mult = 16'd62259;
    miss_sum = 16'd100;
    repeat (2) @(posedge clk);
    @(negedge clk) rst = 1'b0;
    test_directed();
    test_random();
    test_table_full();
    drain();
    repeat (3200) @(posedge clk);
    if (errors == 0 && pending_scores.size() == 0) begin
      $display("keyed_score_accumulator_table: match");
    end else begin
      $display("keyed_score_accumulator_table: mismatch");
    end
    $finish;
  end
endmodule

### files.f
+incdir+sv
sv/ksat_pkg.sv
sv/ksat_ram.sv
sv/ksat_datapath.sv
sv/ksat_ctrl.sv
sv/keyed_score_accumulator_table.sv
tb/tb_top.sv
